// File: rtl/core/blist_pkg.sv
// Shared codes, field widths and defaults for the bounded list block
`default_nettype none

package blist_pkg;

  // default sizing
  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // field widths
  localparam int MODE_W   = 3;
  localparam int POS_W    = 7;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 3;
  localparam int FOUND_W  = 7;
  localparam int COUNT_W  = 7;

  // packed word widths, rounded up to whole bytes
  localparam int S_TDATA_W = ((POS_W + VAL_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((VAL_W + FOUND_W + COUNT_W + 7) / 8) * 8;

  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [STATUS_W-1:0] status_t;

  // request codes
  localparam mode_t MODE_INS_FRONT = 3'd0;
  localparam mode_t MODE_INS_BACK  = 3'd1;
  localparam mode_t MODE_INS_POS   = 3'd2;
  localparam mode_t MODE_DEL_FRONT = 3'd3;
  localparam mode_t MODE_DEL_BACK  = 3'd4;
  localparam mode_t MODE_DEL_POS   = 3'd5;
  localparam mode_t MODE_SEARCH    = 3'd6;

  // result status codes
  localparam status_t STAT_OK       = 3'd0;
  localparam status_t STAT_FULL     = 3'd1;
  localparam status_t STAT_EMPTY    = 3'd2;
  localparam status_t STAT_BADPOS   = 3'd3;
  localparam status_t STAT_NOTFOUND = 3'd4;

endpackage

`default_nettype wire

// File: rtl/core/blist_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port
`default_nettype none

module blist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/bounded_list_insert_delete_search.sv
// Flow: failed requests and inserts at the front or the back go from the start state
//   straight to the result state; walks read the ring store in a walk state first
//   (search visits up to count entries, delete at 0-based k>0 count-k, front delete one,
//   positional insert count-k, then its final write in the put state).
// Throughput: one request at a time; the ring store's single read port visits one
//   entry a cycle during a walk, and the result state waits while the output is stalled.
// Reset: rst clears head, count, sequencer and valid flags; the store is not cleared.
`default_nettype none

module bounded_list_insert_delete_search
  import blist_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // position [6:0], value [38:7], zero fill above
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
  // mode [2:0]
  input  wire logic [MODE_W-1:0]    s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // removed_value [31:0], found_position [38:32], count_after [45:39], zero fill above
  output logic [M_TDATA_W-1:0]      m_axis_tdata,
  // status [2:0]
  output logic [STATUS_W-1:0]       m_axis_tuser
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

  // sequencer codes
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_START  = 3'd1;
  localparam logic [2:0] S_INS    = 3'd2;
  localparam logic [2:0] S_PUT    = 3'd3;
  localparam logic [2:0] S_DEL    = 3'd4;
  localparam logic [2:0] S_SRCH   = 3'd5;
  localparam logic [2:0] S_RESULT = 3'd6;

  // ring index of a 0-based list position
  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] h, input logic [CW-1:0] x);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(x);
    if (s >= (CW+1)'(CAPACITY)) begin
      s = s - (CW+1)'(CAPACITY);
    end
    return s[IW-1:0];
  endfunction

  logic [2:0]            state;
  logic [IW-1:0]         head;
  logic [CW-1:0]         count;
  mode_t                 req_mode;
  logic [POS_W-1:0]      req_pos;
  logic [DATA_WIDTH-1:0] req_word;
  logic [CW-1:0]         k_idx;
  logic [CW-1:0]         end_idx;
  logic [CW-1:0]         rj;
  logic                  rd_on;
  logic                  dv;
  logic [CW-1:0]         di;
  status_t               res_status;
  logic [VAL_W-1:0]      res_removed;
  logic [FOUND_W-1:0]    res_found;
  status_t               out_status;
  logic [VAL_W-1:0]      out_removed;
  logic [FOUND_W-1:0]    out_found;
  logic [COUNT_W-1:0]    out_count;
  logic                  out_valid;

  logic                  ram_we;
  logic [IW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [IW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  logic                  s_accept;
  logic                  out_free;
  logic                  walking;
  logic [PW-1:0]         posx;
  logic [PW-1:0]         cntx;
  logic [CW-1:0]         pos_k;
  logic [CW-1:0]         ins_k;
  logic [CW-1:0]         del_k;
  logic                  ins_bad;
  logic                  del_bad;
  logic                  full;
  logic                  is_ins;
  logic                  put_front;
  logic                  put_back;
  logic [IW-1:0]         head_dec;
  logic [IW-1:0]         head_inc;

  assign s_axis_tready = (state == S_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;
  assign walking       = (state == S_INS) || (state == S_DEL) || (state == S_SRCH);

  // request checks against the current count
  assign posx    = PW'(req_pos);
  assign cntx    = PW'(count);
  assign pos_k   = CW'(posx - PW'(1));
  assign ins_bad = (req_mode == MODE_INS_POS) && ((posx == '0) || (posx > cntx + PW'(1)));
  assign del_bad = (req_mode == MODE_DEL_POS) && ((posx == '0) || (posx > cntx));
  assign full    = (count == CW'(CAPACITY));
  assign is_ins  = (req_mode == MODE_INS_FRONT) || (req_mode == MODE_INS_BACK) ||
                   (req_mode == MODE_INS_POS);

  always_comb begin
    priority if (req_mode == MODE_INS_FRONT) begin
      ins_k = '0;
    end else if (req_mode == MODE_INS_BACK) begin
      ins_k = count;
    end else begin
      ins_k = pos_k;
    end
  end

  always_comb begin
    priority if (req_mode == MODE_DEL_FRONT) begin
      del_k = '0;
    end else if (req_mode == MODE_DEL_BACK) begin
      del_k = count - CW'(1);
    end else begin
      del_k = pos_k;
    end
  end

  // inserts that need a single write and no shifting
  assign put_front = (state == S_START) && is_ins && !ins_bad && !full && (ins_k == '0);
  assign put_back  = (state == S_START) && is_ins && !ins_bad && !full && (ins_k != '0) &&
                     (ins_k == count);

  assign head_dec = (head == '0) ? IW'(CAPACITY - 1) : head - IW'(1);
  assign head_inc = (head == IW'(CAPACITY - 1)) ? '0 : head + IW'(1);

  // store port control
  always_comb begin
    ram_raddr = slot_of(head, rj);
    ram_we    = 1'b0;
    ram_waddr = slot_of(head, count);
    ram_wdata = req_word;
    unique case (state)
      S_START: begin
        ram_we    = put_front || put_back;
        ram_waddr = put_front ? head_dec : slot_of(head, count);
      end
      S_INS: begin
        ram_we    = dv;
        ram_waddr = slot_of(head, di + CW'(1));
        ram_wdata = ram_rdata;
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = slot_of(head, k_idx);
      end
      S_DEL: begin
        ram_we    = dv && (di != k_idx);
        ram_waddr = slot_of(head, di - CW'(1));
        ram_wdata = ram_rdata;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  blist_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer, walk counters and list bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      rd_on     <= 1'b0;
      dv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      dv <= rd_on && walking;
      di <= rj;
      if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          rd_on <= 1'b0;
          if (s_accept) begin
            req_mode    <= s_axis_tuser;
            req_pos     <= s_axis_tdata[POS_W-1:0];
            req_word    <= DATA_WIDTH'(signed'(s_axis_tdata[POS_W +: VAL_W]));
            res_status  <= STAT_OK;
            res_removed <= '0;
            res_found   <= '0;
            state       <= S_START;
          end
        end
        S_START: begin
          state <= S_RESULT;
          unique case (req_mode)
            MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_POS: begin
              priority if (ins_bad) begin
                res_status <= STAT_BADPOS;
              end else if (full) begin
                res_status <= STAT_FULL;
              end else if (put_front) begin
                head  <= head_dec;
                count <= count + CW'(1);
              end else if (put_back) begin
                count <= count + CW'(1);
              end else begin
                rj    <= count - CW'(1);
                k_idx <= ins_k;
                rd_on <= 1'b1;
                state <= S_INS;
              end
            end
            MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DEL_POS: begin
              priority if (count == '0) begin
                res_status <= STAT_EMPTY;
              end else if (del_bad) begin
                res_status <= STAT_BADPOS;
              end else begin
                rj      <= del_k;
                k_idx   <= del_k;
                end_idx <= (del_k == '0) ? '0 : count - CW'(1);
                rd_on   <= 1'b1;
                state   <= S_DEL;
              end
            end
            MODE_SEARCH: begin
              if (count == '0) begin
                res_status <= STAT_EMPTY;
              end else begin
                rj      <= '0;
                end_idx <= count - CW'(1);
                rd_on   <= 1'b1;
                state   <= S_SRCH;
              end
            end
            default: begin
              res_status <= STAT_BADPOS;
            end
          endcase
        end
        S_INS: begin
          // read downward, each word lands one place further back
          if (rd_on) begin
            if (rj == k_idx) begin
              rd_on <= 1'b0;
            end else begin
              rj <= rj - CW'(1);
            end
          end
          if (dv && (di == k_idx)) begin
            state <= S_PUT;
          end
        end
        S_PUT: begin
          count <= count + CW'(1);
          state <= S_RESULT;
        end
        S_DEL: begin
          // first read is the removed word, later reads move one place forward
          if (rd_on) begin
            if (rj == end_idx) begin
              rd_on <= 1'b0;
            end else begin
              rj <= rj + CW'(1);
            end
          end
          if (dv && (di == k_idx)) begin
            res_removed <= VAL_W'(signed'(ram_rdata));
          end
          if (dv && (di == end_idx)) begin
            count <= count - CW'(1);
            if (k_idx == '0) begin
              head <= head_inc;
            end
            state <= S_RESULT;
          end
        end
        S_SRCH: begin
          if (rd_on) begin
            if (rj == end_idx) begin
              rd_on <= 1'b0;
            end else begin
              rj <= rj + CW'(1);
            end
          end
          if (dv) begin
            if (ram_rdata == req_word) begin
              res_found <= FOUND_W'(di + CW'(1));
              rd_on     <= 1'b0;
              state     <= S_RESULT;
            end else if (di == end_idx) begin
              res_status <= STAT_NOTFOUND;
              state      <= S_RESULT;
            end
          end
        end
        S_RESULT: begin
          rd_on <= 1'b0;
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if ((state == S_RESULT) && out_free) begin
      out_status  <= res_status;
      out_removed <= res_removed;
      out_found   <= res_found;
      out_count   <= COUNT_W'(count);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tdata  = {{(M_TDATA_W - VAL_W - FOUND_W - COUNT_W){1'b0}},
                          out_count, out_found, out_removed};

endmodule

`default_nettype wire

// File: rtl/core/blist_checker.sv
// Port-level checks for the bounded list block and their bind
`default_nettype none

module blist_checker
  import blist_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 s_axis_tvalid,
  input wire logic                 s_axis_tready,
  input wire logic [S_TDATA_W-1:0] s_axis_tdata,
  input wire logic [MODE_W-1:0]    s_axis_tuser,
  input wire logic                 m_axis_tvalid,
  input wire logic                 m_axis_tready,
  input wire logic [M_TDATA_W-1:0] m_axis_tdata,
  input wire logic [STATUS_W-1:0]  m_axis_tuser
);

  logic [VAL_W-1:0]   removed;
  logic [FOUND_W-1:0] found;
  logic [COUNT_W-1:0] cnt;

  assign removed = m_axis_tdata[VAL_W-1:0];
  assign found   = m_axis_tdata[VAL_W +: FOUND_W];
  assign cnt     = m_axis_tdata[VAL_W + FOUND_W +: COUNT_W];

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // one request at a time: no accept in the cycle after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after an accepted word");

  // a failed request carries no removed word and no position
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != STAT_OK) |-> (removed == '0) && (found == '0))
    else $error("failed request with nonzero payload");

  // full status only with the list at capacity
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == STAT_FULL) |-> (cnt == COUNT_W'(CAPACITY)))
    else $error("full status with list below capacity");

  // count never above capacity, checked for capacities up to 127
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (CAPACITY > 127) || (int'(cnt) <= CAPACITY))
    else $error("count above capacity");

endmodule

bind bounded_list_insert_delete_search blist_checker #(
  .CAPACITY (CAPACITY)
) u_blist_checker (.*);

`default_nettype wire
